// ===== sv/biquad_pkg.sv =====
// Package with the formats, register indexes, beat types and saturation helpers of the biquad.
package biquad_pkg;

    // Sample format: signed, SAMPLE_WIDTH bits, SAMPLE_WIDTH-1 fraction bits.
    localparam int SAMPLE_WIDTH   = 24;
    // Coefficient format: signed, COEF_WIDTH bits, COEF_FRAC_BITS fraction bits.
    localparam int COEF_WIDTH     = 24;
    localparam int COEF_FRAC_BITS = 20;
    // State words are signed 32 bits with the sample's fraction bits.
    localparam int STATE_WIDTH    = 32;

    localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int RND_WIDTH  = PROD_WIDTH - COEF_FRAC_BITS;
    localparam int ACC_WIDTH  = ((RND_WIDTH > STATE_WIDTH) ? RND_WIDTH : STATE_WIDTH) + 2;

    localparam logic signed [PROD_WIDTH-1:0] RND_HALF =
        PROD_WIDTH'(1) <<< (COEF_FRAC_BITS - 1);

    // Reset value of b0: unity gain, limited to the largest coefficient.
    localparam logic signed [COEF_WIDTH-1:0] COEF_UNITY =
        (COEF_FRAC_BITS < COEF_WIDTH - 1) ? COEF_WIDTH'(1) <<< COEF_FRAC_BITS
                                          : {1'b0, {(COEF_WIDTH-1){1'b1}}};

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [STATE_WIDTH-1:0]  STATE_MAX  = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0]  STATE_MIN  = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

    // Operation codes of an input beat.
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic                           op;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           clipped;
    } t_out_item;

    // Saturates an accumulator value to the sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [ACC_WIDTH-1:0] v
    );
        logic fits;
        fits = (v[ACC_WIDTH-1:SAMPLE_WIDTH-1] == {(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}) ||
               (v[ACC_WIDTH-1:SAMPLE_WIDTH-1] == {(ACC_WIDTH-SAMPLE_WIDTH+1){1'b1}});
        if (fits) begin
            return v[SAMPLE_WIDTH-1:0];
        end else if (v[ACC_WIDTH-1]) begin
            return SAMPLE_MIN;
        end else begin
            return SAMPLE_MAX;
        end
    endfunction

    // Saturates an accumulator value to the state range.
    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [ACC_WIDTH-1:0] v
    );
        logic fits;
        fits = (v[ACC_WIDTH-1:STATE_WIDTH-1] == {(ACC_WIDTH-STATE_WIDTH+1){1'b0}}) ||
               (v[ACC_WIDTH-1:STATE_WIDTH-1] == {(ACC_WIDTH-STATE_WIDTH+1){1'b1}});
        if (fits) begin
            return v[STATE_WIDTH-1:0];
        end else if (v[ACC_WIDTH-1]) begin
            return STATE_MIN;
        end else begin
            return STATE_MAX;
        end
    endfunction

endpackage

// ===== sv/biquad_iir_filter.sv =====
// Top level of the biquad section: registers, sequencer, shared multiplier and output stage.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+---------------------------------
//  input    | in        | i_in_valid / o_in_ready  | i_in_item  (op, sample_in)
//  output   | out       | o_out_valid / i_out_ready| o_out_item (sample_out, clipped)
//  config   | in        | i_cfg_we (no wait)       | i_cfg_index, i_cfg_data
//
// A filter beat runs through the accept cycle and six sequencer steps, one per use
// of the single 24x24 multiplier (five products) plus the final state update.
// A flush beat clears both state words in its accept cycle and the block is ready again
// on the next cycle; it produces no output beat.
// A finished result waits in the output register while the next input beat is accepted;
// the sequencer holds in its last step only if the previous result is still not taken.
// Reset (synchronous, active low) clears the state words, the sequencer and the output
// valid flag, and loads the coefficients with unity gain in b0 and zero elsewhere.
module biquad_iir_filter
    import biquad_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  t_in_item                   i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_out_item                  o_out_item,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [COEF_WIDTH-1:0]      i_cfg_data
);

    // Sequencer steps. Each step except idle and the last drives one product into r_prod.
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an input beat
    localparam logic [2:0] ST_B0   = 3'd1;  // b0*x
    localparam logic [2:0] ST_Y    = 3'd2;  // y = sat(b0*x + w1); b1*x
    localparam logic [2:0] ST_A1   = 3'd3;  // acc = b1*x + w2; a1*y
    localparam logic [2:0] ST_B2   = 3'd4;  // acc -= a1*y; b2*x
    localparam logic [2:0] ST_A2   = 3'd5;  // w1 = sat(acc); acc = b2*x; a2*y
    localparam logic [2:0] ST_W2   = 3'd6;  // w2 = sat(acc - a2*y); emit result

    logic [2:0] r_state, n_state;

    logic signed [COEF_WIDTH-1:0]   r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [STATE_WIDTH-1:0]  r_w1, n_w1, r_w2, n_w2;
    logic signed [SAMPLE_WIDTH-1:0] r_x, n_x, r_y, n_y;
    logic                           r_clip, n_clip;
    logic signed [RND_WIDTH-1:0]    r_prod, n_prod;
    logic signed [ACC_WIDTH-1:0]    r_acc, n_acc;
    logic                           r_out_valid, n_out_valid;
    t_out_item                      r_out_item, n_out_item;

    // Shared multiplier operands and rounded product.
    logic signed [COEF_WIDTH-1:0]   mul_coef;
    logic signed [SAMPLE_WIDTH-1:0] mul_val;
    logic signed [PROD_WIDTH-1:0]   mul_full;
    logic signed [PROD_WIDTH-1:0]   mul_biased;
    logic signed [RND_WIDTH-1:0]    mul_rnd;

    logic signed [ACC_WIDTH-1:0]    y_full;
    logic signed [ACC_WIDTH-1:0]    w2_full;
    logic                           in_fire;
    logic                           out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Operand selection follows the step: x for feedforward, y for feedback terms.
    always_comb begin
        case (r_state)
            ST_B0: begin
                mul_coef = r_b0;
                mul_val  = r_x;
            end
            ST_Y: begin
                mul_coef = r_b1;
                mul_val  = r_x;
            end
            ST_A1: begin
                mul_coef = r_a1;
                mul_val  = r_y;
            end
            ST_B2: begin
                mul_coef = r_b2;
                mul_val  = r_x;
            end
            ST_A2: begin
                mul_coef = r_a2;
                mul_val  = r_y;
            end
            default: begin
                mul_coef = r_b0;
                mul_val  = r_x;
            end
        endcase
    end

    // Round half up: add half an LSB of the result, then floor by an arithmetic shift.
    assign mul_full   = PROD_WIDTH'(mul_coef) * PROD_WIDTH'(mul_val);
    assign mul_biased = mul_full + RND_HALF;
    assign mul_rnd    = RND_WIDTH'(mul_biased >>> COEF_FRAC_BITS);

    assign y_full  = ACC_WIDTH'(r_prod) + ACC_WIDTH'(r_w1);
    assign w2_full = r_acc - ACC_WIDTH'(r_prod);

    always_comb begin
        n_state     = r_state;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_x         = r_x;
        n_y         = r_y;
        n_clip      = r_clip;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_item.op == OP_FLUSH) begin
                        n_w1 = '0;
                        n_w2 = '0;
                    end else begin
                        n_x     = i_in_item.sample_in;
                        n_state = ST_B0;
                    end
                end
            end
            ST_B0: begin
                n_prod  = mul_rnd;
                n_state = ST_Y;
            end
            ST_Y: begin
                // The feedback terms see the saturated output, as the data path does.
                n_y     = sat_sample(y_full);
                n_clip  = (ACC_WIDTH'(sat_sample(y_full)) != y_full);
                n_prod  = mul_rnd;
                n_state = ST_A1;
            end
            ST_A1: begin
                n_acc   = ACC_WIDTH'(r_prod) + ACC_WIDTH'(r_w2);
                n_prod  = mul_rnd;
                n_state = ST_B2;
            end
            ST_B2: begin
                n_acc   = r_acc - ACC_WIDTH'(r_prod);
                n_prod  = mul_rnd;
                n_state = ST_A2;
            end
            ST_A2: begin
                n_w1    = sat_state(r_acc);
                n_acc   = ACC_WIDTH'(r_prod);
                n_prod  = mul_rnd;
                n_state = ST_W2;
            end
            ST_W2: begin
                // Hold here until the output register can take the new result.
                if (out_free) begin
                    n_w2                  = sat_state(w2_full);
                    n_out_valid           = 1'b1;
                    n_out_item.sample_out = r_y;
                    n_out_item.clipped    = r_clip;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_w1        <= '0;
            r_w2        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_w1        <= n_w1;
            r_w2        <= n_w2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_clip     <= n_clip;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_out_item <= n_out_item;
    end

    // Coefficient registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= COEF_UNITY;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_B0:  r_b0 <= i_cfg_data;
                REG_B1:  r_b1 <= i_cfg_data;
                REG_B2:  r_b2 <= i_cfg_data;
                REG_A1:  r_a1 <= i_cfg_data;
                REG_A2:  r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A filter beat keeps the input side closed on the following cycle.
    a_busy_after_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.op == OP_FILTER) |=> !o_in_ready)
        else $error("input accepted while a filter beat is in progress");

    // A flush beat leaves both state words at zero.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.op == OP_FLUSH) |=> (r_w1 == '0 && r_w2 == '0))
        else $error("flush did not clear the state words");

    // A new result appears only from the last sequencer step.
    a_out_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_W2))
        else $error("output beat raised outside the last step");

    // A clipped result sits at one end of the sample range.
    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.clipped) |->
            (o_out_item.sample_out == SAMPLE_MAX || o_out_item.sample_out == SAMPLE_MIN))
        else $error("clip flag set on an unsaturated sample");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the biquad section: directed and random beats against a predictor.
`timescale 1ns / 100ps

module tb;
    import biquad_pkg::*;

    // Run shape. SETTLE_CYCLES of idle time after the last result is enough for any flush
    // still in flight to settle.
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_SETS   = 8;
    localparam int BEATS_PER_SET = 200;
    localparam int HOLD_SET      = 3;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 5000;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    // Receiver behaviors; each one lasts for a random stretch of cycles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_EVERY_THIRD,
        RX_MOSTLY,
        RX_RARELY
    } t_rx_mode;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       o_in_ready;
    t_in_item                   in_item     = '0;
    logic                       o_out_valid;
    logic                       out_ready   = 1'b0;
    t_out_item                  o_out_item;
    logic                       cfg_we      = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index   = '0;
    logic [COEF_WIDTH-1:0]      cfg_data    = '0;

    biquad_iir_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin : clock_gen
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Beats waiting to be offered, and filtered samples waiting to come out.
    t_in_item  pending_beats_q[$];
    t_out_item expected_out_q[$];

    // Shadow copy of the coefficient registers and of the two delay words.
    logic signed [COEF_WIDTH-1:0] coef_shadow [REG_A2 + 1];
    longint                       w1_shadow;
    longint                       w2_shadow;

    logic     in_taken     = 1'b0;
    logic     hold_req     = 1'b0;
    logic     hold_started = 1'b0;
    int       hold_left    = 0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       mode_left    = 0;
    int       rx_tick      = 0;
    t_rx_mode rx_mode      = RX_OPEN;
    int       idle_cycles  = 0;

    int mismatch_count = 0;
    int n_filter       = 0;
    int n_flush        = 0;
    int n_results      = 0;
    int n_clipped      = 0;
    int n_cfg_writes   = 0;
    int n_coef_sets    = 0;

    // Product of a Q4.20 coefficient and a Q.23 value, rounded half up to 23 fraction
    // bits. The arithmetic shift of a signed value floors, which is what rounding needs.
    function automatic longint round_mul(input longint c, input longint v);
        return (c * v + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // One filter beat through the transposed direct form II section. The feedback
    // terms use the saturated output, and both delay words saturate silently. With
    // 24-bit samples and Q4.20 coefficients the delay words stay far inside 32 bits.
    function automatic t_out_item biquad_predict(input logic signed [SAMPLE_WIDTH-1:0] x_in);
        longint    x;
        longint    y_full;
        longint    y;
        longint    w1_next;
        longint    w2_next;
        t_out_item res;
        x       = x_in;
        y_full  = round_mul(coef_shadow[REG_B0], x) + w1_shadow;
        y       = clamp_to(y_full, longint'(SAMPLE_MIN), longint'(SAMPLE_MAX));
        w1_next = round_mul(coef_shadow[REG_B1], x) - round_mul(coef_shadow[REG_A1], y)
                  + w2_shadow;
        w2_next = round_mul(coef_shadow[REG_B2], x) - round_mul(coef_shadow[REG_A2], y);
        w1_shadow = clamp_to(w1_next, longint'(STATE_MIN), longint'(STATE_MAX));
        w2_shadow = clamp_to(w2_next, longint'(STATE_MIN), longint'(STATE_MAX));
        res.sample_out = y[SAMPLE_WIDTH-1:0];
        res.clipped    = (y != y_full);
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // Samples lean toward the rails and toward small values, where rounding matters.
    function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return SAMPLE_WIDTH'(int'($urandom_range(0, 8191)) - 4096);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // Coefficients mix the extremes, unity, values within +/-1.0 and the full range.
    function automatic logic [COEF_WIDTH-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return COEF_UNITY;
            3, 4, 5: return COEF_WIDTH'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            default: return COEF_WIDTH'($urandom);
        endcase
    endfunction

    task automatic add_beat(input logic op, input logic [SAMPLE_WIDTH-1:0] sample);
        t_in_item beat;
        beat.op        = op;
        beat.sample_in = sample;
        pending_beats_q.push_back(beat);
    endtask

    // Register writes go out at the falling edge and take effect at the next rising edge.
    task automatic write_coef(input logic [CFG_INDEX_WIDTH-1:0] idx,
                              input logic [COEF_WIDTH-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_all_coefs(input logic [COEF_WIDTH-1:0] b0,
                                   input logic [COEF_WIDTH-1:0] b1,
                                   input logic [COEF_WIDTH-1:0] b2,
                                   input logic [COEF_WIDTH-1:0] a1,
                                   input logic [COEF_WIDTH-1:0] a2);
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
        n_coef_sets++;
    endtask

    // Waits until every queued beat went in and every expected sample came out, then
    // lets a trailing flush finish before anything touches the registers. A hang here
    // is caught by the watchdog.
    task automatic drain();
        while (pending_beats_q.size() != 0 || in_valid || expected_out_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: offers beats from the pending queue at the falling edge, in bursts of random
    // length separated by random gaps. A beat that is not yet taken stays on the bus.
    always @(negedge i_clk) begin : driver
        logic     next_valid;
        t_in_item next_item;
        next_valid = in_valid && !in_taken;
        next_item  = in_item;
        if (!next_valid && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_beats_q.size() != 0) begin
                next_item  = pending_beats_q.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7, 8: gap_left = $urandom_range(1, 12);
                        default: gap_left = $urandom_range(13, 40);
                    endcase
                end
            end
        end
        in_valid <= next_valid;
        in_item  <= next_item;
    end

    // Receiver: follows a stall pattern of its own. Once asked, it holds off for a long
    // stretch so the output register fills, the next beat parks inside and input stalls.
    always @(negedge i_clk) begin : receiver
        logic ready;
        rx_tick++;
        if (hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
        end else begin
            if (mode_left > 0) begin
                mode_left--;
            end else begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            case (rx_mode)
                RX_OPEN:        ready = 1'b1;
                RX_EVERY_THIRD: ready = (rx_tick % 3 == 0);
                RX_MOSTLY:      ready = ($urandom_range(0, 9) < 7);
                default:        ready = ($urandom_range(0, 9) < 2);
            endcase
        end
        out_ready <= ready;
    end

    // Monitor: at each rising edge it checks an output beat against the oldest expected
    // sample first, then tracks register writes, then predicts for an accepted input beat.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        in_taken <= i_rst_n && in_valid && o_in_ready;
        if (!i_rst_n) begin
            coef_shadow[REG_B0] = COEF_UNITY;
            coef_shadow[REG_B1] = '0;
            coef_shadow[REG_B2] = '0;
            coef_shadow[REG_A1] = '0;
            coef_shadow[REG_A2] = '0;
            w1_shadow = 0;
            w2_shadow = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                n_results++;
                if (o_out_item.clipped) begin
                    n_clipped++;
                end
                if (expected_out_q.size() == 0) begin
                    note_failure($sformatf("output beat with nothing expected: sample_out %0d",
                                           o_out_item.sample_out));
                end else begin
                    want = expected_out_q.pop_front();
                    if (o_out_item.sample_out !== want.sample_out) begin
                        note_failure($sformatf("sample_out: expected %0d, got %0d",
                                               want.sample_out, o_out_item.sample_out));
                    end
                    if (o_out_item.clipped !== want.clipped) begin
                        note_failure($sformatf("clipped: expected %0b, got %0b",
                                               want.clipped, o_out_item.clipped));
                    end
                end
            end
            // Indexes beyond the last coefficient are ignored by the block.
            if (cfg_we) begin
                n_cfg_writes++;
                if (cfg_index <= REG_A2) begin
                    coef_shadow[cfg_index] = cfg_data;
                end
            end
            if (in_valid && o_in_ready) begin
                if (in_item.op == OP_FLUSH) begin
                    n_flush++;
                    w1_shadow = 0;
                    w2_shadow = 0;
                end else begin
                    n_filter++;
                    expected_out_q.push_back(biquad_predict(in_item.sample_in));
                end
            end
        end
    end

    // Watchdog: any handshake counts as progress; a long run of cycles without one means
    // the block is stuck and the run is ended as a failure.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d beats still expected",
                     $realtime, idle_cycles, expected_out_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: unity gain, so the output should follow the input exactly.
        add_beat(OP_FILTER, '0);
        add_beat(OP_FILTER, SAMPLE_MAX);
        add_beat(OP_FILTER, SAMPLE_MIN);
        add_beat(OP_FILTER, SAMPLE_WIDTH'(-1));
        add_beat(OP_FILTER, SAMPLE_WIDTH'(1));
        add_beat(OP_FLUSH, SAMPLE_WIDTH'($urandom));
        add_beat(OP_FILTER, SAMPLE_WIDTH'(24'h400000));
        drain();

        // Extreme coefficients: a gain near eight drives the output to both rails, and
        // heavy feedback pushes the delay words around. Writes past the last index must
        // leave the coefficients alone.
        write_all_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
        for (int k = REG_A2 + 1; k < 2 ** CFG_INDEX_WIDTH; k++) begin
            write_coef(CFG_INDEX_WIDTH'(k), COEF_WIDTH'($urandom));
        end
        add_beat(OP_FILTER, SAMPLE_MAX);
        add_beat(OP_FILTER, SAMPLE_MIN);
        add_beat(OP_FILTER, '0);
        add_beat(OP_FILTER, SAMPLE_WIDTH'(1));
        add_beat(OP_FILTER, SAMPLE_WIDTH'(-1));
        add_beat(OP_FLUSH, SAMPLE_MAX);
        add_beat(OP_FILTER, SAMPLE_MAX);
        add_beat(OP_FILTER, '0);
        add_beat(OP_FILTER, '0);
        drain();

        // Random coefficient sets, each followed by a stream of beats with occasional
        // flushes. One set runs with the receiver held off to back the block up.
        for (int s = 0; s < RANDOM_SETS; s++) begin
            write_all_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
            if ($urandom_range(0, 2) == 0) begin
                write_coef(CFG_INDEX_WIDTH'($urandom_range(REG_A2 + 1,
                                                           2 ** CFG_INDEX_WIDTH - 1)),
                           COEF_WIDTH'($urandom));
            end
            if (s == HOLD_SET) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < BEATS_PER_SET; n++) begin
                if ($urandom_range(0, 99) < 6) begin
                    add_beat(OP_FLUSH, SAMPLE_WIDTH'($urandom));
                end else begin
                    add_beat(OP_FILTER, rand_sample());
                end
            end
            drain();
        end

        $display("Covered %0d filter beats and %0d flushes over %0d coefficient sets (%0d writes).",
                 n_filter, n_flush, n_coef_sets, n_cfg_writes);
        $display("Checked %0d output beats, %0d clipped; %0d failures, one long receiver hold.",
                 n_results, n_clipped, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
